@@ design/mdio_fm_pkg.sv @@
`default_nettype none
package mdio_fm_pkg;

    // Frame timing
    localparam int unsigned SLOT_W = 7;
    localparam logic [SLOT_W-1:0] PREAMBLE_BITS  = 7'd32;
    localparam logic [SLOT_W-1:0] READ_DRIVEN    = 7'd15;
    localparam logic [SLOT_W-1:0] READ_RELEASED  = 7'd19;
    localparam logic [SLOT_W-1:0] WRITE_DRIVEN   = 7'd32;
    localparam logic [SLOT_W-1:0] WRITE_RELEASED = 7'd2;

    localparam int unsigned FRAME_W  = 32;
    localparam int unsigned SAMPLE_W = 19;
    localparam int unsigned DATA_W   = 16;

    // Fixed frame heads: read is extra 1, start 01, opcode 10; write is start 01, opcode 01
    localparam logic [4:0] READ_HEAD  = 5'b10110;
    localparam logic [3:0] WRITE_HEAD = 4'b0101;
    localparam logic [1:0] WRITE_TA   = 2'b10;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_IDLE    = 2'd0,
        STATUS_SLOT    = 2'd1,
        STATUS_ACCEPT  = 2'd2,
        STATUS_REFUSED = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic                mdio_out;
        logic                mdio_drive;
        logic                frame_done;
        logic [DATA_W-1:0]   read_data;
    } result_t;

endpackage
`default_nettype wire

@@ design/mdio_fm_core.sv @@
`default_nettype none
module mdio_fm_core
    import mdio_fm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [1:0]        command,
    input  wire logic [4:0]        phy_id,
    input  wire logic [4:0]        reg_addr,
    input  wire logic [DATA_W-1:0] write_data,
    input  wire logic              mdio_in,
    output result_t                result
);

    logic [FRAME_W-1:0]  frame_shift_reg,  frame_shift_next;
    logic [SLOT_W-1:0]   slot_count_reg,   slot_count_next;
    logic                busy_flag_reg,    busy_flag_next;
    logic                read_mode_reg,    read_mode_next;
    logic [SAMPLE_W-1:0] sample_shift_reg, sample_shift_next;

    logic [SLOT_W-1:0] driven;
    logic [SLOT_W-1:0] total;
    logic [SLOT_W-1:0] slot_inc;
    cmd_t              cmd;

    assign cmd      = cmd_t'(command);
    assign driven   = read_mode_reg ? READ_DRIVEN : WRITE_DRIVEN;
    assign total    = PREAMBLE_BITS + driven
                      + (read_mode_reg ? READ_RELEASED : WRITE_RELEASED);
    assign slot_inc = slot_count_reg + 7'd1;

    // One transaction: start a frame, refuse a start while busy, or play one bit slot
    always_comb begin
        frame_shift_next  = frame_shift_reg;
        slot_count_next   = slot_count_reg;
        busy_flag_next    = busy_flag_reg;
        read_mode_next    = read_mode_reg;
        sample_shift_next = sample_shift_reg;
        result.status     = STATUS_IDLE;
        result.mdio_out   = 1'b0;
        result.mdio_drive = 1'b0;
        result.frame_done = 1'b0;
        result.read_data  = '0;

        unique case (cmd)
            CMD_READ, CMD_WRITE: begin
                if (busy_flag_reg) begin
                    result.status = STATUS_REFUSED;
                end else begin
                    result.status     = STATUS_ACCEPT;
                    busy_flag_next    = 1'b1;
                    slot_count_next   = '0;
                    sample_shift_next = '0;
                    if (cmd == CMD_READ) begin
                        read_mode_next   = 1'b1;
                        frame_shift_next = {READ_HEAD, phy_id, reg_addr, 17'd0};
                    end else begin
                        read_mode_next   = 1'b0;
                        frame_shift_next = {WRITE_HEAD, phy_id, reg_addr, WRITE_TA,
                                            write_data};
                    end
                end
            end
            default: begin
                if (busy_flag_reg) begin
                    result.status = STATUS_SLOT;
                    if (slot_count_reg < PREAMBLE_BITS) begin
                        result.mdio_out   = 1'b1;
                        result.mdio_drive = 1'b1;
                    end else if (slot_count_reg < PREAMBLE_BITS + driven) begin
                        result.mdio_out   = frame_shift_reg[FRAME_W-1];
                        result.mdio_drive = 1'b1;
                        frame_shift_next  = {frame_shift_reg[FRAME_W-2:0], 1'b0};
                    end else if (read_mode_reg) begin
                        sample_shift_next = {sample_shift_reg[SAMPLE_W-2:0], mdio_in};
                    end

                    slot_count_next = slot_inc;
                    if (slot_inc >= total) begin
                        result.frame_done = 1'b1;
                        if (read_mode_reg) begin
                            result.read_data = sample_shift_next[DATA_W:1];
                        end
                        busy_flag_next  = 1'b0;
                        slot_count_next = '0;
                    end
                end
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_shift_reg  <= '0;
            slot_count_reg   <= '0;
            busy_flag_reg    <= 1'b0;
            read_mode_reg    <= 1'b0;
            sample_shift_reg <= '0;
        end else if (step) begin
            frame_shift_reg  <= frame_shift_next;
            slot_count_reg   <= slot_count_next;
            busy_flag_reg    <= busy_flag_next;
            read_mode_reg    <= read_mode_next;
            sample_shift_reg <= sample_shift_next;
        end
    end

endmodule
`default_nettype wire

@@ design/mdio_management_frame_master.sv @@
// Output: a result is registered and appears on the m_ side in the cycle after its input transaction.
// Throughput: one transaction per cycle; the single output register takes a new
//   result whenever it is empty or being drained in the same cycle.
// Reset: aresetn is synchronous, active low; it empties the output register and
//   returns the frame engine to idle with all frame state cleared.
`default_nettype none
module mdio_management_frame_master
    import mdio_fm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic [4:0]        s_phy_id,
    input  wire logic [4:0]        s_reg_addr,
    input  wire logic [DATA_W-1:0] s_write_data,
    input  wire logic              s_mdio_in,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic                   m_mdio_out,
    output logic                   m_mdio_drive,
    output logic                   m_frame_done,
    output logic [DATA_W-1:0]      m_read_data
);

    logic    accept;
    result_t core_result;
    logic    m_valid_reg;
    result_t result_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mdio_fm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .command    (s_command),
        .phy_id     (s_phy_id),
        .reg_addr   (s_reg_addr),
        .write_data (s_write_data),
        .mdio_in    (s_mdio_in),
        .result     (core_result)
    );

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= core_result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = result_reg.status;
    assign m_mdio_out   = result_reg.mdio_out;
    assign m_mdio_drive = result_reg.mdio_drive;
    assign m_frame_done = result_reg.frame_done;
    assign m_read_data  = result_reg.read_data;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import mdio_fm_pkg::*;

    // Every frame, read or write, is 66 bit slots long
    localparam int FRAME_SLOTS  = 66;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_TAIL   = 250;
    localparam int CYCLE_LIMIT  = 400000;

    // Tracks the frame engine and queues the result each transaction should produce
    class mdio_slot_predictor;
        localparam int LEAD_ONES   = 32;
        localparam int RD_DRIVEN   = 15;
        localparam int RD_RELEASED = 19;
        localparam int WR_DRIVEN   = 32;
        localparam int WR_RELEASED = 2;
        localparam logic [4:0] RD_OPENING = 5'b10110;  // extra 1, start 01, opcode 10
        localparam logic [3:0] WR_OPENING = 4'b0101;   // start 01, opcode 01
        localparam logic [1:0] WR_TURN    = 2'b10;

        logic [31:0] frame_bits;
        logic [6:0]  slot_idx;
        bit          busy;
        bit          is_read;
        logic [18:0] samples;
        result_t     expected_slots[$];
        int          fail_count;

        function new();
            frame_bits = '0;
            slot_idx   = '0;
            busy       = 1'b0;
            is_read    = 1'b0;
            samples    = '0;
            fail_count = 0;
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction

        function void note_transaction(cmd_t cmd, logic [4:0] phy, logic [4:0] regno,
                                       logic [15:0] wdata, logic din);
            result_t r;
            int driven;
            int total;
            r = '0;
            r.status = STATUS_IDLE;
            if (cmd == CMD_READ || cmd == CMD_WRITE) begin
                if (busy) begin
                    r.status = STATUS_REFUSED;
                end else begin
                    r.status = STATUS_ACCEPT;
                    busy     = 1'b1;
                    slot_idx = '0;
                    samples  = '0;
                    is_read  = (cmd == CMD_READ);
                    if (is_read)
                        frame_bits = {RD_OPENING, phy, regno, 17'd0};
                    else
                        frame_bits = {WR_OPENING, phy, regno, WR_TURN, wdata};
                end
            end else if (busy) begin
                // tick or unused code 3: play the next slot
                driven = is_read ? RD_DRIVEN : WR_DRIVEN;
                total  = LEAD_ONES + driven + (is_read ? RD_RELEASED : WR_RELEASED);
                r.status = STATUS_SLOT;
                if (slot_idx < LEAD_ONES) begin
                    r.mdio_out   = 1'b1;
                    r.mdio_drive = 1'b1;
                end else if (slot_idx < LEAD_ONES + driven) begin
                    r.mdio_out   = frame_bits[31];
                    r.mdio_drive = 1'b1;
                    frame_bits   = frame_bits << 1;
                end else if (is_read) begin
                    samples = {samples[17:0], din};
                end
                slot_idx = slot_idx + 7'd1;
                if (slot_idx >= total) begin
                    r.frame_done = 1'b1;
                    if (is_read)
                        r.read_data = samples[16:1];
                    busy     = 1'b0;
                    slot_idx = '0;
                end
            end
            expected_slots.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic dout, logic drv, logic done,
                                   logic [15:0] rdata);
            result_t e;
            if (expected_slots.size() == 0) begin
                $error("result transaction with no expected result pending");
                fail_count++;
                return;
            end
            e = expected_slots.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                fail_count++;
            end
            if (dout !== e.mdio_out) begin
                $error("mdio_out: expected %0d, actual %0d", e.mdio_out, dout);
                fail_count++;
            end
            if (drv !== e.mdio_drive) begin
                $error("mdio_drive: expected %0d, actual %0d", e.mdio_drive, drv);
                fail_count++;
            end
            if (done !== e.frame_done) begin
                $error("frame_done: expected %0d, actual %0d", e.frame_done, done);
                fail_count++;
            end
            if (rdata !== e.read_data) begin
                $error("read_data: expected 0x%04h, actual 0x%04h", e.read_data, rdata);
                fail_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [4:0]  s_phy_id;
    logic [4:0]  s_reg_addr;
    logic [15:0] s_write_data;
    logic        s_mdio_in;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_mdio_out;
    logic        m_mdio_drive;
    logic        m_frame_done;
    logic [15:0] m_read_data;

    mdio_slot_predictor slot_model = new();
    int idle_pct    = 0;
    int stall_left  = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    mdio_management_frame_master uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_phy_id     (s_phy_id),
        .s_reg_addr   (s_reg_addr),
        .s_write_data (s_write_data),
        .s_mdio_in    (s_mdio_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_mdio_out   (m_mdio_out),
        .m_mdio_drive (m_mdio_drive),
        .m_frame_done (m_frame_done),
        .m_read_data  (m_read_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** mdio_management_frame_master: FAILED **");
            $finish;
        end
    end

    // Monitor: check results first, then predict for the newly accepted transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                slot_model.check_result(m_status, m_mdio_out, m_mdio_drive, m_frame_done,
                                        m_read_data);
            if (s_valid && s_ready)
                slot_model.note_transaction(cmd_t'(s_command), s_phy_id, s_reg_addr,
                                            s_write_data, s_mdio_in);
        end
    end

    // Result side backpressure in random bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
                stall_left = $urandom_range(9, 1) - 1;
                m_ready    = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Present one transaction, with an optional gap in front, and hold it until taken
    task automatic send_item(input logic [1:0] cmd, input logic [4:0] phy,
                             input logic [4:0] regno, input logic [15:0] wdata,
                             input logic din);
        @(negedge aclk);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge aclk);
        end
        s_command    = cmd;
        s_phy_id     = phy;
        s_reg_addr   = regno;
        s_write_data = wdata;
        s_mdio_in    = din;
        s_valid      = 1'b1;
        items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One start followed by a full frame of ticks; din_mode 0 random, 1 all low, 2 all high
    task automatic run_frame(input cmd_t kind, input logic [4:0] phy, input logic [4:0] regno,
                             input logic [15:0] wdata, input int din_mode,
                             input int noise_pct);
        int slots;
        int roll;
        logic din;
        send_item(kind, phy, regno, wdata, 1'($urandom));
        slots = 0;
        while (slots < FRAME_SLOTS) begin
            roll = $urandom_range(99, 0);
            if (roll < noise_pct) begin
                // start while busy: must be refused without disturbing the frame
                send_item($urandom_range(1, 0) ? CMD_READ : CMD_WRITE, 5'($urandom),
                          5'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                din = (din_mode == 0) ? 1'($urandom) : (din_mode == 2);
                send_item((roll < 2 * noise_pct) ? CMD_RSVD : CMD_TICK, 5'($urandom),
                          5'($urandom), 16'($urandom), din);
                slots++;
            end
        end
    endtask

    task automatic wait_for_results();
        while (slot_model.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int random_goal;
        int din_mode;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_TICK;
        s_phy_id     = '0;
        s_reg_addr   = '0;
        s_write_data = '0;
        s_mdio_in    = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: idle ticks, address and data extremes, refused starts, code 3
        idle_pct = 15;
        send_item(CMD_TICK, 5'h1f, 5'h1f, 16'hffff, 1'b1);
        send_item(CMD_RSVD, 5'h00, 5'h00, 16'h0000, 1'b0);
        run_frame(CMD_READ, 5'h1f, 5'h00, 16'h0000, 2, 6);
        run_frame(CMD_READ, 5'h00, 5'h1f, 16'hffff, 1, 0);
        run_frame(CMD_WRITE, 5'h1f, 5'h1f, 16'hffff, 0, 0);
        run_frame(CMD_WRITE, 5'h00, 5'h00, 16'h0000, 0, 6);
        run_frame(CMD_READ, 5'h15, 5'h0a, 16'h0000, 0, 3);

        // Sender holds off until the block has drained
        @(negedge aclk);
        s_valid = 1'b0;
        wait_for_results();

        // Random frames with idle noise between them; quiet tail at the end
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            if (items_sent >= random_goal - QUIET_TAIL)
                idle_pct = 0;
            else
                idle_pct = ($urandom_range(3, 0) == 0) ? 0 : 15;
            if ($urandom_range(2, 0) == 0)
                repeat ($urandom_range(3, 1))
                    send_item($urandom_range(1, 0) ? CMD_TICK : CMD_RSVD, 5'($urandom),
                              5'($urandom), 16'($urandom), 1'($urandom));
            case ($urandom_range(5, 0))
                0: din_mode = 1;
                1: din_mode = 2;
                default: din_mode = 0;
            endcase
            run_frame($urandom_range(1, 0) ? CMD_READ : CMD_WRITE, 5'($urandom),
                      5'($urandom), 16'($urandom), din_mode,
                      ($urandom_range(3, 0) == 0) ? 0 : 4);
        end

        @(negedge aclk);
        s_valid = 1'b0;
        wait_for_results();
        repeat (8) @(posedge aclk);

        if (slot_model.fail_count == 0 && slot_model.pending() == 0)
            $display("** mdio_management_frame_master: PASSED **");
        else
            $display("** mdio_management_frame_master: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mdio_fm_pkg.sv
design/mdio_fm_core.sv
design/mdio_management_frame_master.sv
sim/tb.sv
